/* rtl/core/sctf_pkg.sv */
// Shared types, constants and CRC/hex helper functions for the sentence CRC-16 trailer framer.
package sctf_pkg;

    localparam logic [15:0] CRC_SEED    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [7:0]  STAR_CHAR   = 8'h2A;
    localparam logic [7:0]  DIGIT_BASE  = 8'h30;
    localparam logic [7:0]  LETTER_BASE = 8'h37;
    localparam logic [3:0]  POS_MAX     = 4'hF;
    localparam logic [3:0]  SKIP_RESET  = 4'd2;
    localparam logic [3:0]  DIGIT_LIMIT = 4'd10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < DIGIT_LIMIT)
        begin
            ch = DIGIT_BASE + {4'h0, nib};
        end
        else
        begin
            ch = LETTER_BASE + {4'h0, nib};
        end
        return ch;
    endfunction

endpackage

/* rtl/core/sctf_in_stage.sv */
// Input register stage that holds one accepted sentence byte until the output stage takes it.
module sctf_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  logic [7:0]      data_byte,
    input  logic            is_last,
    input  logic            take,
    output logic            s1_valid,
    output sctf_pkg::item_t s1_item
);
    import sctf_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign item_ready = !valid_reg || take;
    assign accept     = item_valid && item_ready;
    assign s1_valid   = valid_reg;
    assign s1_item    = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data <= data_byte;
            item_reg.last <= is_last;
        end
    end

endmodule

/* rtl/core/sctf_crc_track.sv */
// Running CRC-16, byte position counter and the skip count configuration register.
module sctf_crc_track (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [3:0]      skip_count,
    input  logic            take,
    input  sctf_pkg::item_t item,
    output logic [15:0]     crc_after
);
    import sctf_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [3:0]  skip_reg;
    logic [3:0]  skip_next;
    logic [15:0] crc_upd;

    assign cfg_ready = 1'b1;
    assign crc_upd   = (pos_reg >= skip_reg) ? crc16_byte(crc_reg, item.data) : crc_reg;
    assign crc_after = crc_upd;

    always_comb
    begin
        crc_next  = crc_reg;
        pos_next  = pos_reg;
        skip_next = skip_reg;
        if (cfg_valid && cfg_ready)
        begin
            skip_next = skip_count;
        end
        if (take)
        begin
            if (item.last)
            begin
                crc_next = CRC_SEED;
                pos_next = 4'd0;
            end
            else
            begin
                crc_next = crc_upd;
                if (pos_reg != POS_MAX)
                begin
                    pos_next = pos_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_SEED;
            pos_reg  <= 4'd0;
            skip_reg <= SKIP_RESET;
        end
        else
        begin
            crc_reg  <= crc_next;
            pos_reg  <= pos_next;
            skip_reg <= skip_next;
        end
    end

    a_sentence_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.last |=> crc_reg == CRC_SEED && pos_reg == 4'd0)
        else $error("CRC state did not restart after the last byte of a sentence.");

endmodule

/* rtl/core/sctf_out_stage.sv */
// Result register with the trailer sequencer that emits the star and four hex CRC digits.
module sctf_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s1_valid,
    input  sctf_pkg::item_t s1_item,
    input  logic [15:0]     crc_after,
    output logic            take,
    output logic            result_valid,
    input  logic            result_ready,
    output logic [7:0]      out_byte,
    output logic            end_of_run
);
    import sctf_pkg::*;

    localparam logic [2:0] TRL_NONE = 3'd0;
    localparam logic [2:0] TRL_HEX0 = 3'd1;
    localparam logic [2:0] TRL_HEX1 = 3'd2;
    localparam logic [2:0] TRL_HEX2 = 3'd3;
    localparam logic [2:0] TRL_HEX3 = 3'd4;
    localparam logic [2:0] TRL_STAR = 3'd5;

    logic [2:0]  trl_reg;
    logic [2:0]  trl_next;
    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  byte_reg;
    logic [7:0]  byte_next;
    logic        end_reg;
    logic        end_next;
    logic [15:0] snap_reg;
    logic [15:0] snap_next;
    logic        free;

    assign free         = !valid_reg || result_ready;
    assign take         = free && (trl_reg == TRL_NONE) && s1_valid;
    assign result_valid = valid_reg;
    assign out_byte     = byte_reg;
    assign end_of_run   = end_reg;

    always_comb
    begin
        trl_next   = trl_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        end_next   = end_reg;
        snap_next  = snap_reg;
        if (free)
        begin
            end_next   = 1'b0;
            valid_next = 1'b1;
            case (trl_reg)
                TRL_NONE:
                begin
                    valid_next = s1_valid;
                    byte_next  = s1_item.data;
                    if (s1_valid && s1_item.last)
                    begin
                        trl_next  = TRL_STAR;
                        snap_next = crc_after;
                    end
                end
                TRL_STAR:
                begin
                    byte_next = STAR_CHAR;
                    trl_next  = TRL_HEX3;
                end
                TRL_HEX3:
                begin
                    byte_next = hex_char(snap_reg[15:12]);
                    trl_next  = TRL_HEX2;
                end
                TRL_HEX2:
                begin
                    byte_next = hex_char(snap_reg[11:8]);
                    trl_next  = TRL_HEX1;
                end
                TRL_HEX1:
                begin
                    byte_next = hex_char(snap_reg[7:4]);
                    trl_next  = TRL_HEX0;
                end
                TRL_HEX0:
                begin
                    byte_next = hex_char(snap_reg[3:0]);
                    end_next  = 1'b1;
                    trl_next  = TRL_NONE;
                end
                default:
                begin
                    valid_next = 1'b0;
                    trl_next   = TRL_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trl_reg   <= TRL_NONE;
            valid_reg <= 1'b0;
        end
        else
        begin
            trl_reg   <= trl_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        end_reg  <= end_next;
        snap_reg <= snap_next;
    end

    a_trailer_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        trl_reg != TRL_NONE |-> valid_reg)
        else $error("Trailer in progress without a valid result in the output register.");

    a_end_closes_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && end_reg |-> trl_reg == TRL_NONE)
        else $error("End of sentence shown while trailer characters are still pending.");

    a_star_first: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && trl_reg == TRL_HEX3 |-> byte_reg == STAR_CHAR)
        else $error("Trailer did not open with the star character.");

    a_no_take_in_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        trl_reg != TRL_NONE |-> !take)
        else $error("Input byte taken while the trailer is being emitted.");

endmodule

/* rtl/core/sentence_crc16_trailer_framer.sv */
// Top level of the sentence CRC-16 trailer framer.
//
// Sentence bytes arrive on the item channel (item_valid, item_ready, data_byte,
// is_last) and leave on the result channel (result_valid, result_ready, out_byte,
// end_of_run). Every byte is echoed; after the byte marked is_last the block
// sends '*' and the CRC-16 (seed FFFF, polynomial 1021) as four upper-case hex
// characters, the last one flagged with end_of_run.
// The cfg channel (cfg_valid, cfg_ready, skip_count) sets how many leading bytes
// of each sentence stay out of the checksum; it should be written while idle.
// A byte passes through the input register and then the result register before
// it reaches the result channel. Ordinary bytes stream at one per cycle while
// the receiver accepts them; a last byte and its trailer leave the result register
// as six bytes, and during the trailer the input register holds one further byte
// and then stalls the item channel. The CRC update is a single unrolled 8-bit
// step between the input register and the result register.
// When the receiver stalls, the result register holds its byte and the stall
// backs up through the input register to item_ready.
// Reset empties both registers, sets the CRC to FFFF, the position to zero and
// skip_count to 2.
module sentence_crc16_trailer_framer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] skip_count,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] data_byte,
    input  logic       is_last,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] out_byte,
    output logic       end_of_run
);
    import sctf_pkg::*;

    logic        take;
    logic        s1_valid;
    item_t       s1_item;
    logic [15:0] crc_after;

    sctf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .data_byte  (data_byte),
        .is_last    (is_last),
        .take       (take),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item)
    );

    sctf_crc_track u_crc_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .skip_count (skip_count),
        .take       (take),
        .item       (s1_item),
        .crc_after  (crc_after)
    );

    sctf_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid),
        .s1_item      (s1_item),
        .crc_after    (crc_after),
        .take         (take),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .end_of_run   (end_of_run)
    );

endmodule
